>>> hw/rtl/bfd_pkg.sv
// shared types and constants for the length-prefixed frame deframer
`timescale 1ns / 1ps

package bfd_pkg;

  // payload store size and its address width
  localparam int BUF_BYTES = 256;
  localparam int ADDR_W    = $clog2(BUF_BYTES);

  // frame marker bytes
  localparam logic [7:0] HDR1_BYTE = 8'ha0;
  localparam logic [7:0] HDR2_BYTE = 8'ha2;
  localparam logic [7:0] TRL1_BYTE = 8'hb0;
  localparam logic [7:0] TRL2_BYTE = 8'hb3;

  // longest length that still fits the store
  localparam logic [14:0] MAX_LEN = 15'(BUF_BYTES - 1);

  // operation codes
  localparam logic OP_RX   = 1'b0;
  localparam logic OP_READ = 1'b1;

  // result kinds
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_CSUM_BAD    = 2'd1,
    STATUS_TOO_LONG    = 2'd2,
    STATUS_TRAILER_BAD = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    PS_HDR1 = 4'd0,
    PS_HDR2 = 4'd1,
    PS_LEN1 = 4'd2,
    PS_LEN2 = 4'd3,
    PS_BODY = 4'd4,
    PS_SUM1 = 4'd5,
    PS_SUM2 = 4'd6,
    PS_TRL1 = 4'd7,
    PS_TRL2 = 4'd8
  } parse_state_t;

endpackage

>>> hw/rtl/binary_frame_deframer_sum15_core.sv
// top level of the length-prefixed frame deframer with a 15-bit payload sum
//
// input channel: in_valid / in_stall carry one item per cycle; op 0 feeds one
// received byte (rx_byte) to the frame parser, op 1 reads the stored payload
// byte at read_index
// frames are a0 a2, 15-bit length (high byte first), payload, 16-bit sum,
// b0 b3; payload bytes go into a 256-byte synchronous payload memory
// output channel: out_valid / out_stall; kind 0 is a frame end report
// (status, frame_length, msg_type), kind 1 carries read_data
// throughput: one item per cycle while in_stall is low; the parser updates its registers and does
// one memory write per byte, a read uses the single memory read port
// path: the memory read and the pipe stage load at the edge that accepts an
// item; the output register loads from the pipe stage when it can move on
// items that cause no result (most stream bytes) leave nothing behind
// stall: a pipe register and the output register give two places for
// results, so items are still taken while one result waits; in_stall rises
// only when both are full and the receiver stalls
// reset: the parser waits for a0, both result registers are emptied; the
// payload memory is not cleared and holds garbage until written
`timescale 1ns / 1ps

module binary_frame_deframer_sum15_core
  import bfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [1:0]  status,
  output logic [14:0] frame_length,
  output logic [7:0]  msg_type,
  output logic [7:0]  read_data
);

  // parser registers
  parse_state_t      state, state_next;
  logic              drop_payload, drop_payload_next;
  logic              sum_ok, sum_ok_next;
  logic [14:0]       length_reg, length_reg_next;
  logic [14:0]       bytes_left, bytes_left_next;
  logic [14:0]       running_sum, running_sum_next;
  logic [7:0]        sum_hi, sum_hi_next;
  logic [ADDR_W-1:0] write_pos, write_pos_next;
  logic [7:0]        type_byte, type_byte_next;

  // payload memory
  logic [7:0]        mem [BUF_BYTES];
  logic              mem_we;
  logic [7:0]        rd_data;
  logic              rd_in_range;

  // pipe stage and output register
  logic              p_valid;
  logic              p_kind;
  status_t           p_status;
  logic [14:0]       p_len;
  logic [7:0]        p_type;
  logic              o_valid;
  logic              o_kind;
  status_t           o_status;
  logic [14:0]       o_len;
  logic [7:0]        o_type;
  logic [7:0]        o_data;

  logic              in_accept;
  logic              move;
  logic              report;
  logic              trailer_good;
  status_t           rep_status;
  logic [14:0]       new_len;
  logic [14:0]       left_dec;
  logic [15:0]       rx_sum;

  // handshake: stall only when both result places are occupied and held
  assign move      = p_valid && (!o_valid || !out_stall);
  assign in_stall  = p_valid && o_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign new_len  = {length_reg[14:8], rx_byte};
  assign left_dec = bytes_left - 15'd1;
  assign rx_sum   = {sum_hi, rx_byte};

  // frame parser: next state and register updates
  always_comb begin
    state_next        = state;
    drop_payload_next = drop_payload;
    sum_ok_next       = sum_ok;
    length_reg_next   = length_reg;
    bytes_left_next   = bytes_left;
    running_sum_next  = running_sum;
    sum_hi_next       = sum_hi;
    write_pos_next    = write_pos;
    type_byte_next    = type_byte;
    mem_we            = 1'b0;
    report            = 1'b0;
    trailer_good      = 1'b0;
    if (in_accept && op == OP_RX) begin
      unique case (state)
        PS_HDR1: begin
          if (rx_byte == HDR1_BYTE) state_next = PS_HDR2;
        end
        PS_HDR2: begin
          state_next = (rx_byte == HDR2_BYTE) ? PS_LEN1 : PS_HDR1;
        end
        PS_LEN1: begin
          length_reg_next = {rx_byte[6:0], 8'h00};
          state_next      = PS_LEN2;
        end
        PS_LEN2: begin
          length_reg_next   = new_len;
          bytes_left_next   = new_len;
          running_sum_next  = '0;
          write_pos_next    = '0;
          sum_ok_next       = 1'b0;
          drop_payload_next = (new_len > MAX_LEN);
          // empty payload goes straight to the checksum
          state_next        = (new_len == 15'd0) ? PS_SUM1 : PS_BODY;
        end
        PS_BODY: begin
          if (!drop_payload) begin
            mem_we           = 1'b1;
            write_pos_next   = write_pos + 1'b1;
            running_sum_next = running_sum + 15'(rx_byte);
            if (write_pos == '0) type_byte_next = rx_byte;
          end
          bytes_left_next = left_dec;
          if (left_dec == 15'd0) state_next = PS_SUM1;
        end
        PS_SUM1: begin
          sum_hi_next = rx_byte;
          state_next  = PS_SUM2;
        end
        PS_SUM2: begin
          // top received bit set never matches the 15-bit sum
          sum_ok_next = !drop_payload && ({1'b0, running_sum} == rx_sum);
          state_next  = PS_TRL1;
        end
        PS_TRL1: begin
          if (rx_byte == TRL1_BYTE) begin
            state_next = PS_TRL2;
          end else begin
            report     = 1'b1;
            state_next = PS_HDR1;
          end
        end
        PS_TRL2: begin
          report       = 1'b1;
          trailer_good = (rx_byte == TRL2_BYTE);
          state_next   = PS_HDR1;
        end
        default: state_next = PS_HDR1;
      endcase
    end
  end

  // status priority: trailer, oversize, checksum
  always_comb begin
    priority if (!trailer_good) rep_status = STATUS_TRAILER_BAD;
    else if (drop_payload)      rep_status = STATUS_TOO_LONG;
    else if (!sum_ok)           rep_status = STATUS_CSUM_BAD;
    else                        rep_status = STATUS_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= PS_HDR1;
      drop_payload <= 1'b0;
      sum_ok       <= 1'b0;
      length_reg   <= '0;
      bytes_left   <= '0;
      running_sum  <= '0;
      sum_hi       <= '0;
      write_pos    <= '0;
      type_byte    <= '0;
    end else begin
      state        <= state_next;
      drop_payload <= drop_payload_next;
      sum_ok       <= sum_ok_next;
      length_reg   <= length_reg_next;
      bytes_left   <= bytes_left_next;
      running_sum  <= running_sum_next;
      sum_hi       <= sum_hi_next;
      write_pos    <= write_pos_next;
      type_byte    <= type_byte_next;
    end
  end

  // payload memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[write_pos] <= rx_byte;
  end

  // read data holds while its result sits in the pipe stage
  always_ff @(posedge clk) begin
    if (in_accept && op == OP_READ) begin
      rd_data     <= mem[ADDR_W'(read_index)];
      rd_in_range <= (32'(read_index) < BUF_BYTES);
    end
  end

  // pipe stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (in_accept && (op == OP_READ || report)) begin
      p_valid <= 1'b1;
    end else if (move) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && op == OP_READ) begin
      p_kind   <= KIND_READ;
      p_status <= STATUS_OK;
      p_len    <= '0;
      p_type   <= '0;
    end else if (in_accept && report) begin
      p_kind   <= KIND_REPORT;
      p_status <= rep_status;
      p_len    <= length_reg;
      // type byte only when a payload was actually stored
      p_type   <= (!drop_payload && length_reg != 15'd0) ? type_byte : 8'h00;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (move) begin
      o_valid <= 1'b1;
    end else if (!out_stall) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      o_kind   <= p_kind;
      o_status <= p_status;
      o_len    <= p_len;
      o_type   <= p_type;
      o_data   <= (p_kind == KIND_READ && rd_in_range) ? rd_data : 8'h00;
    end
  end

  assign out_valid    = o_valid;
  assign kind         = o_kind;
  assign status       = o_status;
  assign frame_length = o_len;
  assign msg_type     = o_type;
  assign read_data    = o_data;

endmodule

>>> tb/binary_frame_deframer_sum15_core_tb.sv
// self-checking testbench for the length-prefixed frame deframer with a 15-bit payload sum
`timescale 1ns / 1ps

module binary_frame_deframer_sum15_core_tb;
  import bfd_pkg::*;

  // how the checksum bytes of a frame are formed from the payload sum
  typedef enum logic [1:0] {
    CS_GOOD = 2'd0,   // matching sum, top bit clear
    CS_FLIP = 2'd1,   // lowest bit flipped
    CS_TOP  = 2'd2,   // matching low bits but top bit set
    CS_RAND = 2'd3    // any 16-bit value
  } csum_mode_t;

  // one result item as it leaves the block
  typedef struct packed {
    logic        kind;
    status_t     status;
    logic [14:0] flen;
    logic [7:0]  mtype;
    logic [7:0]  rdata;
  } deframe_res_t;

  // one row of the directed frame table
  typedef struct packed {
    logic [7:0]  h1;
    logic [7:0]  h2;
    logic [7:0]  lhi;
    logic [7:0]  llo;
    logic [7:0]  fill;
    csum_mode_t  cmode;
    logic [7:0]  t1;
    logic [7:0]  t2;
    logic        mid_read;
    logic [7:0]  rd_idx;
    logic        typed;
    status_t     xstatus;
    logic [14:0] xlen;
    logic [7:0]  xtype;
  } frame_row_t;

  typedef logic [7:0] byte_q_t [$];

  localparam int NUM_ROWS     = 15;
  localparam int RANDOM_ITEMS = 400;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        op;
  logic [7:0]  rx_byte;
  logic [7:0]  read_index;
  logic        out_valid;
  logic        out_stall;
  logic        kind;
  logic [1:0]  status;
  logic [14:0] frame_length;
  logic [7:0]  msg_type;
  logic [7:0]  read_data;

  binary_frame_deframer_sum15_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .rx_byte      (rx_byte),
    .read_index   (read_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .status       (status),
    .frame_length (frame_length),
    .msg_type     (msg_type),
    .read_data    (read_data)
  );

  // percentages of idle cycles on the sending and receiving side
  int gap_pct   = 0;
  int stall_pct = 0;
  int errors    = 0;
  int quiet_cycles = 0;

  // results still owed by the block, oldest first
  deframe_res_t pending_results [$];

  // a directed row may type in the frame end report it expects
  bit           typed_armed = 1'b0;
  deframe_res_t typed_res;

  // parser shadow state
  parse_state_t ps          = PS_HDR1;
  bit           drop        = 1'b0;
  bit           sum_good    = 1'b0;
  logic [14:0]  hdr_len     = '0;
  logic [14:0]  remaining   = '0;
  logic [14:0]  psum        = '0;
  logic [15:0]  got_sum     = '0;
  logic [7:0]   wr_ptr      = '0;
  logic [7:0]   shadow_payload [BUF_BYTES];
  bit           shadow_written [BUF_BYTES];
  logic [7:0]   written_slots [$];

  frame_row_t directed_rows [NUM_ROWS];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  task automatic note_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      note_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  // next-state and result of the deframer for one accepted item
  function automatic void deframe_step(input logic o, input logic [7:0] b,
                                       input logic [7:0] ri, output bit got,
                                       output deframe_res_t r);
    bit fin;
    bit trl_ok;
    got    = 1'b0;
    r      = '0;
    fin    = 1'b0;
    trl_ok = 1'b1;
    if (o == OP_READ) begin
      // reads never disturb the parser
      got     = 1'b1;
      r.kind  = KIND_READ;
      r.rdata = shadow_payload[ri];
      return;
    end
    case (ps)
      PS_HDR1: if (b == HDR1_BYTE) ps = PS_HDR2;
      PS_HDR2: ps = (b == HDR2_BYTE) ? PS_LEN1 : PS_HDR1;
      PS_LEN1: begin
        // top bit of the high length byte is not part of the length
        hdr_len = {b[6:0], 8'h00};
        ps      = PS_LEN2;
      end
      PS_LEN2: begin
        hdr_len   = hdr_len + 15'(b);
        remaining = hdr_len;
        psum      = '0;
        wr_ptr    = '0;
        sum_good  = 1'b0;
        drop      = hdr_len > MAX_LEN;
        ps        = (hdr_len == 0) ? PS_SUM1 : PS_BODY;
      end
      PS_BODY: begin
        if (!drop) begin
          shadow_payload[wr_ptr] = b;
          if (!shadow_written[wr_ptr]) begin
            shadow_written[wr_ptr] = 1'b1;
            written_slots.push_back(wr_ptr);
          end
          wr_ptr = wr_ptr + 8'd1;
          psum   = psum + 15'(b);
        end
        remaining = remaining - 15'd1;
        if (remaining == 0) ps = PS_SUM1;
      end
      PS_SUM1: begin
        got_sum = {b, 8'h00};
        ps      = PS_SUM2;
      end
      PS_SUM2: begin
        got_sum[7:0] = b;
        // 15-bit sum against all 16 received bits
        sum_good = !drop && ({1'b0, psum} == got_sum);
        ps       = PS_TRL1;
      end
      PS_TRL1: begin
        if (b == TRL1_BYTE) ps = PS_TRL2;
        else begin
          fin    = 1'b1;
          trl_ok = 1'b0;
        end
      end
      PS_TRL2: begin
        fin    = 1'b1;
        trl_ok = (b == TRL2_BYTE);
      end
      default: ps = PS_HDR1;
    endcase
    if (fin) begin
      got    = 1'b1;
      r.kind = KIND_REPORT;
      if (!trl_ok)       r.status = STATUS_TRAILER_BAD;
      else if (drop)     r.status = STATUS_TOO_LONG;
      else if (!sum_good) r.status = STATUS_CSUM_BAD;
      else               r.status = STATUS_OK;
      r.flen  = hdr_len;
      r.mtype = (!drop && hdr_len != 0) ? shadow_payload[0] : 8'h00;
      ps      = PS_HDR1;
    end
  endfunction

  // present one item, wait for it to be taken, then log what it owes
  task automatic put_item(input logic o, input logic [7:0] b, input logic [7:0] ri);
    bit           take;
    bit           got;
    deframe_res_t r;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < gap_pct) @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= o;
    rx_byte    <= b;
    read_index <= ri;
    // stall is settled by the falling edge, inputs only move on rising ones
    do begin
      @(negedge clk);
      take = !in_stall;
      @(posedge clk);
    end while (!take);
    deframe_step(o, b, ri, got, r);
    if (got) begin
      if (r.kind == KIND_REPORT && typed_armed) begin
        r           = typed_res;
        typed_armed = 1'b0;
      end
      pending_results.push_back(r);
    end
  endtask

  task automatic put_byte(input logic [7:0] b);
    put_item(OP_RX, b, 8'($urandom));
  endtask

  // reads only go to store positions written since reset
  task automatic read_at(input logic [7:0] idx);
    if (shadow_written[idx]) put_item(OP_READ, 8'($urandom), idx);
  endtask

  task automatic read_any();
    if (written_slots.size() != 0)
      put_item(OP_READ, 8'($urandom),
               written_slots[$urandom_range(0, written_slots.size() - 1)]);
  endtask

  // one frame; the payload length must agree with the length bytes
  task automatic send_frame(input logic [7:0] h1, input logic [7:0] h2,
                            input logic [7:0] lhi, input logic [7:0] llo,
                            input byte_q_t body, input csum_mode_t cmode,
                            input logic [7:0] t1, input logic [7:0] t2,
                            input logic mid_read, input logic [7:0] mid_idx,
                            input int read_pct);
    logic [14:0] run;
    logic [15:0] ck;
    run = '0;
    put_byte(h1);
    put_byte(h2);
    // a broken header ends the attempt here
    if (h1 != HDR1_BYTE || h2 != HDR2_BYTE) return;
    put_byte(lhi);
    put_byte(llo);
    foreach (body[j]) begin
      put_byte(body[j]);
      run = run + 15'(body[j]);
      if (read_pct != 0 && $urandom_range(0, 99) < read_pct) read_any();
    end
    if (mid_read) read_at(mid_idx);
    case (cmode)
      CS_GOOD: ck = {1'b0, run};
      CS_FLIP: ck = {1'b0, run} ^ 16'h0001;
      CS_TOP:  ck = {1'b1, run};
      default: ck = 16'($urandom);
    endcase
    put_byte(ck[15:8]);
    put_byte(ck[7:0]);
    put_byte(t1);
    if (t1 == TRL1_BYTE) put_byte(t2);
  endtask

  // compare each result taken by the receiver with the oldest expectation
  always @(negedge clk) begin : result_check
    deframe_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("result kind %0d with nothing expected", kind));
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 16'(kind), 16'(want.kind));
        check_field("status", 16'(status), 16'(want.status));
        check_field("frame_length", 16'(frame_length), 16'(want.flen));
        check_field("msg_type", 16'(msg_type), 16'(want.mtype));
        check_field("read_data", 16'(read_data), 16'(want.rdata));
      end
    end
  end

  // watchdog: too long without any item moving on either side
  always @(negedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[%0t] watchdog expired, %0d results outstanding", $realtime,
               pending_results.size());
      $display("binary_frame_deframer_sum15_core_tb: FAIL");
      $finish;
    end
  end

  initial begin
    byte_q_t     body;
    frame_row_t  row;
    logic [14:0] n;
    logic [7:0]  t1;
    logic [7:0]  t2;
    logic [7:0]  x;
    csum_mode_t  cm;
    int          pick;
    int          cnt;
    int          rand_items;

    rst        = 1'b1;
    in_valid   = 1'b0;
    op         = OP_RX;
    rx_byte    = '0;
    read_index = '0;
    out_stall  = 1'b0;
    rand_items = 0;
    foreach (shadow_written[i]) begin
      shadow_written[i] = 1'b0;
      shadow_payload[i] = '0;
    end

    // directed frames:
    // h1 h2 lhi llo fill csum t1 t2 | mid-read idx | typed status len type
    directed_rows = '{
      // garbage before any header, then a wrong second header byte
      '{'h00, 'h7f, 'h00, 'h00, 'h00, CS_GOOD, 'hb0, 'hb3, 0, 0, 0, STATUS_OK, 0, 'h00},
      '{'ha0, 'h00, 'h00, 'h00, 'h00, CS_GOOD, 'hb0, 'hb3, 0, 0, 0, STATUS_OK, 0, 'h00},
      // empty payload, good and bad sum
      '{'ha0, 'ha2, 'h00, 'h00, 'h00, CS_GOOD, 'hb0, 'hb3, 0, 0, 1, STATUS_OK, 0, 'h00},
      '{'ha0, 'ha2, 'h00, 'h00, 'h00, CS_FLIP, 'hb0, 'hb3, 0, 0, 1, STATUS_CSUM_BAD, 0, 'h00},
      '{'ha0, 'ha2, 'h00, 'h01, 'hff, CS_GOOD, 'hb0, 'hb3, 0, 0, 1, STATUS_OK, 1, 'hff},
      // sum top bit set never matches; read just after a write
      '{'ha0, 'ha2, 'h00, 'h03, 'h00, CS_TOP, 'hb0, 'hb3, 1, 2, 1, STATUS_CSUM_BAD, 3, 'h00},
      // largest payload that fits
      '{'ha0, 'ha2, 'h00, 'hff, 'h80, CS_GOOD, 'hb0, 'hb3, 1, 254, 1, STATUS_OK, 255, 'h80},
      // oversized: smallest one, and one with the length high bit set
      '{'ha0, 'ha2, 'h01, 'h00, 'h11, CS_GOOD, 'hb0, 'hb3, 0, 128, 1, STATUS_TOO_LONG, 256, 'h00},
      '{'ha0, 'ha2, 'h81, 'h00, 'h00, CS_GOOD, 'hb0, 'hb3, 0, 1, 1, STATUS_TOO_LONG, 256, 'h00},
      // length high bit ignored
      '{'ha0, 'ha2, 'h80, 'h02, 'h5a, CS_GOOD, 'hb0, 'hb3, 0, 0, 1, STATUS_OK, 2, 'h5a},
      // trailer faults, first and second byte
      '{'ha0, 'ha2, 'h00, 'h02, 'h33, CS_GOOD, 'h00, 'h00, 0, 1, 1, STATUS_TRAILER_BAD, 2, 'h33},
      '{'ha0, 'ha2, 'h00, 'h02, 'h44, CS_GOOD, 'hb0, 'h00, 0, 1, 1, STATUS_TRAILER_BAD, 2, 'h44},
      // trailer fault outranks too long
      '{'ha0, 'ha2, 'h01, 'h2c, 'h00, CS_GOOD, 'hb0, 'hb2, 0, 0, 1, STATUS_TRAILER_BAD, 300, 'h00},
      '{'ha0, 'ha2, 'h00, 'h04, 'hc3, CS_FLIP, 'hb0, 'hb3, 0, 3, 0, STATUS_OK, 0, 'h00},
      '{'ha0, 'ha2, 'h00, 'h10, 'h7e, CS_GOOD, 'hb0, 'hb3, 1, 1, 0, STATUS_OK, 0, 'h00}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // phase one: sender rarely idle, receiver mostly stalled
    gap_pct   = 7;
    stall_pct = 69;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      body.delete();
      n = {row.lhi[6:0], row.llo};
      for (int j = 0; j < int'(n); j++) body.push_back(8'(row.fill + j));
      typed_res        = '0;
      typed_res.kind   = KIND_REPORT;
      typed_res.status = row.xstatus;
      typed_res.flen   = row.xlen;
      typed_res.mtype  = row.xtype;
      typed_armed      = row.typed;
      send_frame(row.h1, row.h2, row.lhi, row.llo, body, row.cmode, row.t1, row.t2,
                 row.mid_read, row.rd_idx, 0);
      if (!row.mid_read) read_at(row.rd_idx);
      typed_armed = 1'b0;
    end

    // random traffic, mostly well-formed frames with random content
    while (rand_items < RANDOM_ITEMS) begin
      case (rand_items * 3 / RANDOM_ITEMS)
        0: begin
          gap_pct   = 7;
          stall_pct = 69;
        end
        1: begin
          gap_pct   = 69;
          stall_pct = 7;
        end
        default: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        pick = $urandom_range(0, 99);
        if (pick < 75)      n = 15'($urandom_range(0, 12));
        else if (pick < 92) n = 15'($urandom_range(13, 255));
        else                n = 15'($urandom_range(256, 300));
        body.delete();
        for (int j = 0; j < int'(n); j++) body.push_back(8'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 70)      cm = CS_GOOD;
        else if (pick < 82) cm = CS_FLIP;
        else if (pick < 90) cm = CS_TOP;
        else                cm = CS_RAND;
        t1 = TRL1_BYTE;
        t2 = TRL2_BYTE;
        pick = $urandom_range(0, 99);
        if (pick >= 92) begin
          t2 = 8'($urandom);
          if (t2 == TRL2_BYTE) t2 = 8'h00;
        end else if (pick >= 85) begin
          t1 = 8'($urandom);
          if (t1 == TRL1_BYTE) t1 = 8'h00;
        end
        send_frame(HDR1_BYTE, HDR2_BYTE, {1'($urandom), n[14:8]}, n[7:0], body, cm,
                   t1, t2, 1'b0, 8'h00, 12);
        rand_items += int'(n) + 8;
      end else if (pick < 85) begin
        // burst of reads between frames
        cnt = $urandom_range(1, 4);
        repeat (cnt) read_any();
        rand_items += cnt;
      end else if (pick < 93) begin
        // line noise while waiting for a header; keeps clear of the first marker
        cnt = $urandom_range(1, 4);
        repeat (cnt) begin
          x = 8'($urandom);
          if (x == HDR1_BYTE) x = 8'h55;
          put_byte(x);
        end
      end else begin
        // first header byte followed by anything but the second
        x = 8'($urandom);
        if (x == HDR2_BYTE) x = HDR1_BYTE;
        put_byte(HDR1_BYTE);
        put_byte(x);
        rand_items += 2;
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("binary_frame_deframer_sum15_core_tb: PASS");
    end else begin
      $display("binary_frame_deframer_sum15_core_tb: FAIL");
    end
    $finish;
  end

endmodule
